/* sv/mcoms_pkg.sv */
// Shared types, sizes and helpers for the masked context offer match store.
// No dependencies; every other file imports this package.
package mcoms_pkg;

  localparam int BUCKETS            = 256;
  localparam int ENTRIES_PER_BUCKET = 4;
  localparam int MAX_BRICKS         = 8;
  localparam int BRICK_BITS         = 8;

  localparam int LANES   = 8;
  localparam int LANE_W  = 8;
  localparam int VEC_W   = LANES * LANE_W;
  localparam int LEN_W   = 4;
  localparam int CNT_W   = 3;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int FILL_W  = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int ENT_N   = BUCKETS * ENTRIES_PER_BUCKET;
  localparam int ENT_AW  = (ENT_N > 1) ? $clog2(ENT_N) : 1;

  localparam logic [LANE_W-1:0] LANE_MASK = LANE_W'((1 << BRICK_BITS) - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  localparam logic [1:0] OP_OFFER   = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;

  typedef enum logic [1:0] {
    CLS_OFFER,
    CLS_REQUEST,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_COUNTED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    cls_t              cls;
    logic [BKT_W-1:0]  bucket;
    logic [LEN_W-1:0]  len;
    logic [VEC_W-1:0]  ctx;
    logic [VEC_W-1:0]  msk;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  count;
  } result_t;

  // key modulo BUCKETS, restoring remainder one key bit a step
  function automatic logic [BKT_W-1:0] bucket_of(logic [7:0] k);
    logic [8:0] r;
    int i;
    r = '0;
    for (i = 7; i >= 0; i--) begin
      r = {r[7:0], k[i]};
      if (r >= 9'(BUCKETS)) r = r - 9'(BUCKETS);
    end
    return r[BKT_W-1:0];
  endfunction

  // low BRICK_BITS of each lane below len
  function automatic logic [VEC_W-1:0] lanes_keep(logic [LEN_W-1:0] len);
    logic [VEC_W-1:0] k;
    int i;
    k = '0;
    for (i = 0; i < LANES; i++) begin
      if (i < MAX_BRICKS && LEN_W'(i) < len) k[i*LANE_W +: LANE_W] = LANE_MASK;
    end
    return k;
  endfunction

endpackage

/* sv/mcoms_front.sv */
// Front end: classifies incoming requests and holds them in a two-entry queue.
// Depends on mcoms_pkg.
module mcoms_front import mcoms_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [7:0]          key,
  input  logic [LEN_W-1:0]    brick_count,
  input  logic [VEC_W-1:0]    brick_contexts,
  input  logic [VEC_W-1:0]    brick_masks,
  output logic                item_valid,
  output item_t               item,
  input  logic                item_take
);

  item_t       q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  item_t       cls_item;
  logic [LEN_W-1:0] len_sat;
  logic [VEC_W-1:0] keep;
  logic        wr;
  logic        rd;

  always_comb begin
    len_sat = (brick_count > LEN_W'(MAX_BRICKS)) ? LEN_W'(MAX_BRICKS) : brick_count;
    keep    = lanes_keep(len_sat);
    case (operation)
      OP_OFFER:   cls_item.cls = CLS_OFFER;
      OP_REQUEST: cls_item.cls = CLS_REQUEST;
      default:    cls_item.cls = CLS_OTHER;
    endcase
    cls_item.bucket = bucket_of(key);
    cls_item.len    = len_sat;
    cls_item.ctx    = brick_contexts & keep;
    cls_item.msk    = brick_masks & keep;
  end

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rp];
  assign wr         = push && !full;
  assign rd         = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= cls_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* sv/mcoms_resq.sv */
// Two-entry result queue between the back end and the result ports.
// Depends on mcoms_pkg.
module mcoms_resq import mcoms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     res_push,
  input  result_t  res_in,
  output logic     res_full,
  input  logic     pop,
  output logic     empty,
  output result_t  res_out
);

  result_t     q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        wr;
  logic        rd;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign res_out  = q[rp];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* sv/mcoms_back.sv */
// Back end: bucket fill table and entry memory; stores offers, walks buckets
// for match counts. Depends on mcoms_pkg.
module mcoms_back import mcoms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  item_t    in_item,
  output logic     item_take,
  output logic     res_push,
  output result_t  res,
  input  logic     res_full
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [VEC_W-1:0] ctx;
    logic [VEC_W-1:0] msk;
  } entry_t;

  state_t              state;
  item_t               item;
  logic [FILL_W-1:0]   fill_mem [BUCKETS];
  logic [BUCKETS-1:0]  fill_valid;
  logic [FILL_W-1:0]   fill_rd;
  logic                fill_rd_valid;
  logic [FILL_W-1:0]   fill_now;
  logic [FILL_W-1:0]   fill_cur;
  logic [FILL_W-1:0]   e;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  entry_t              ent_mem [ENT_N];
  entry_t              ent_rd;
  logic                ent_wr;
  logic                ent_rd_en;
  logic [ENT_AW-1:0]   ent_wr_addr;
  logic [ENT_AW-1:0]   ent_rd_addr;
  logic [VEC_W-1:0]    diff;
  logic                hit;
  logic                last;

  function automatic logic [ENT_AW-1:0] ent_addr(logic [BKT_W-1:0] b,
                                                 logic [FILL_W-1:0] idx);
    return ENT_AW'(ENT_AW'(b) * ENT_AW'(ENTRIES_PER_BUCKET) + ENT_AW'(idx));
  endfunction

  always_comb begin
    item_take   = (state == S_IDLE) && item_valid;
    res_push    = (state == S_EMIT) && !res_full;
    fill_now    = fill_rd_valid ? fill_rd : '0;
    ent_wr      = (state == S_FILL) && (item.cls == CLS_OFFER) &&
                  (fill_now < FILL_W'(ENTRIES_PER_BUCKET));
    ent_wr_addr = ent_addr(item.bucket, fill_now);
    last        = (e == FILL_W'(fill_cur - 1'b1));
    ent_rd_en   = 1'b0;
    ent_rd_addr = ent_addr(item.bucket, '0);
    if (state == S_FILL && item.cls == CLS_REQUEST && fill_now != '0) begin
      ent_rd_en = 1'b1;
    end else if (state == S_READ && !last) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = ent_addr(item.bucket, FILL_W'(e + 1'b1));
    end
    // differing bits must be don't-care on both sides
    diff       = ent_rd.ctx ^ item.ctx;
    hit        = (ent_rd.len == item.len) && ((diff & ~ent_rd.msk) == '0) &&
                 ((diff & ~item.msk) == '0);
    count_next = (hit && count != CNT_MAX) ? CNT_W'(count + 1'b1) : count;
  end

  always_ff @(posedge clk) begin
    if (ent_wr) ent_mem[ent_wr_addr] <= '{len: item.len, ctx: item.ctx, msk: item.msk};
    if (ent_rd_en) ent_rd <= ent_mem[ent_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_wr) fill_mem[item.bucket] <= FILL_W'(fill_now + 1'b1);
    if (item_take) begin
      fill_rd       <= fill_mem[in_item.bucket];
      fill_rd_valid <= fill_valid[in_item.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take) begin
            item  <= in_item;
            count <= '0;
            if (in_item.cls == CLS_OTHER) begin
              res   <= '{status: ST_UNKNOWN, count: '0};
              state <= S_EMIT;
            end else begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          fill_cur <= fill_now;
          e        <= '0;
          if (item.cls == CLS_OFFER) begin
            if (ent_wr) begin
              fill_valid[item.bucket] <= 1'b1;
              res <= '{status: ST_STORED, count: '0};
            end else begin
              res <= '{status: ST_DROPPED, count: '0};
            end
            state <= S_EMIT;
          end else if (fill_now == '0) begin
            res   <= '{status: ST_COUNTED, count: '0};
            state <= S_EMIT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          count <= count_next;
          if (last) begin
            res   <= '{status: ST_COUNTED, count: count_next};
            state <= S_EMIT;
          end else begin
            e <= FILL_W'(e + 1'b1);
          end
        end
        S_EMIT: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/masked_context_offer_match_store.sv */
// Top level of the masked context offer match store.
// Depends on mcoms_pkg, mcoms_front, mcoms_back and mcoms_resq.
//
// Input side is a queue: drive operation, key, brick_count, brick_contexts and
// brick_masks with push; the request is taken on a clock edge with push high
// and full low. Offers (operation 0) store the masked brick vector in bucket
// key % BUCKETS; requests (operation 1) count matching entries of that bucket;
// other operations only report status 3.
// Result side is a queue too: while empty is low, status and match_count
// show the oldest result; pop high with empty low takes it. Exactly one
// result per request, in order.
// Sequencing: the back end handles one request at a time. An offer reads the
// bucket fill, writes its entry and then emits its result; an unknown operation
// goes straight to emitting; a match request reads the bucket fill, then reads
// the bucket's n entries one after another from the entry memory, where n is the
// bucket's fill (at most ENTRIES_PER_BUCKET), and then emits its result.
// A two-entry queue in front and a two-entry result queue let input and
// output stall independently; when the result queue is full the back end
// holds its result and the front queue fills, then full rises.
// Synchronous reset empties both queues and marks every bucket empty; entry
// memory keeps its contents and is never read before being written.
module masked_context_offer_match_store import mcoms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        operation,
  input  logic [7:0]        key,
  input  logic [LEN_W-1:0]  brick_count,
  input  logic [VEC_W-1:0]  brick_contexts,
  input  logic [VEC_W-1:0]  brick_masks,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  match_count
);

  item_t    item;
  logic     item_valid;
  logic     item_take;
  logic     res_push;
  logic     res_full;
  result_t  res;
  result_t  res_out;

  mcoms_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .key            (key),
    .brick_count    (brick_count),
    .brick_contexts (brick_contexts),
    .brick_masks    (brick_masks),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take)
  );

  mcoms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .in_item    (item),
    .item_take  (item_take),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  mcoms_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign status      = res_out.status;
  assign match_count = res_out.count;

endmodule
